/* sv/mtcqfd_pkg.sv */
package mtcqfd_pkg;

  typedef enum logic [1:0] {
    CMD_QUARTER_FRAME = 2'd0,
    CMD_FULL_FRAME    = 2'd1,
    CMD_TIMER_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FPS_RATE0 = 2'd0,
    REG_FPS_RATE1 = 2'd1,
    REG_FPS_RATE2 = 2'd2,
    REG_FPS_RATE3 = 2'd3
  } reg_idx_t;

  localparam int unsigned FPS_W     = 5;
  localparam int unsigned NUM_SLOTS = 8;

  localparam logic [FPS_W-1:0] FPS_RATE0_RST = 5'd24;
  localparam logic [FPS_W-1:0] FPS_RATE1_RST = 5'd25;
  localparam logic [FPS_W-1:0] FPS_RATE2_RST = 5'd30;
  localparam logic [FPS_W-1:0] FPS_RATE3_RST = 5'd30;

  localparam logic [2:0] LAST_PIECE  = 3'd7;
  localparam logic [2:0] FIRST_PIECE = 3'd0;
  localparam logic [7:0] SEC_PER_MIN = 8'd60;
  localparam logic [7:0] MIN_PER_HR  = 8'd60;
  localparam logic [4:0] HR_PER_DAY  = 5'd24;
  localparam logic [7:0] MAX_SEC     = 8'd59;
  localparam logic [7:0] MAX_MIN     = 8'd59;
  localparam logic [4:0] MAX_HR      = 5'd23;
  localparam logic [7:0] JUMP_LIMIT  = 8'd2;
  localparam logic [7:0] TICKS_MAX   = 8'd255;

endpackage

/* sv/mtc_quarter_frame_decoder_top.sv */
// MIDI time code decoder. Each input item is a quarter-frame byte, a full-frame
// time message or a frame timer tick, selected by in_command; every item yields
// exactly one result item carrying the current time, a publish flag and a timer
// restart request. The block takes one item per clock cycle while out_ready stays
// high: an item is captured in an input register, decoded in one pass against the
// time state, and lands in the output register in the next cycle if the output
// does not stall. The user must write the frames per second for the four rate
// types through the cfg port only while the block is idle; the block itself does
// not enforce this.
module mtc_quarter_frame_decoder_top
  import mtcqfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_qf_byte,
  input  logic [6:0] in_ff_hour_byte,
  input  logic [6:0] in_ff_minute,
  input  logic [6:0] in_ff_second,
  input  logic [6:0] in_ff_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_publish,
  output logic       out_restart_timer,
  output logic [4:0] out_hours,
  output logic [7:0] out_minutes,
  output logic [7:0] out_seconds,
  output logic [7:0] out_frames,
  output logic [1:0] out_rate_type
);

  // input stage
  logic       s1_valid_r;
  logic [1:0] s1_cmd_r;
  logic [6:0] s1_qf_r;
  logic [6:0] s1_hb_r;
  logic [6:0] s1_min_r;
  logic [6:0] s1_sec_r;
  logic [6:0] s1_frm_r;

  // decoder state
  logic [FPS_W-1:0] fps_r [4];
  logic [3:0]       slots_r [NUM_SLOTS];
  logic [2:0]       last_piece_r;
  logic             forward_r;
  logic [4:0]       hours_r;
  logic [7:0]       minutes_r;
  logic [7:0]       seconds_r;
  logic [7:0]       frames_r;
  logic [1:0]       rate_r;
  logic [7:0]       last_set_r;
  logic [7:0]       jump_r;
  logic [7:0]       ticks_r;

  logic             forward_nxt;
  logic [4:0]       hours_nxt;
  logic [7:0]       minutes_nxt;
  logic [7:0]       seconds_nxt;
  logic [7:0]       frames_nxt;
  logic [1:0]       rate_nxt;
  logic [7:0]       last_set_nxt;
  logic [7:0]       jump_nxt;
  logic [7:0]       ticks_nxt;
  logic             pub_nxt;
  logic             restart_nxt;

  // output stage
  logic       out_valid_r;
  logic       pub_r;
  logic       restart_r;
  logic [4:0] hours_o_r;
  logic [7:0] minutes_o_r;
  logic [7:0] seconds_o_r;
  logic [7:0] frames_o_r;
  logic [1:0] rate_o_r;

  logic fire;
  logic in_fire;

  // quarter frame decode
  logic [2:0]       piece;
  logic [3:0]       nib;
  logic [3:0]       slots_upd [NUM_SLOTS];
  logic             qf_forward;
  logic             qf_complete;
  logic [4:0]       qf_hours;
  logic [7:0]       qf_minutes;
  logic [7:0]       qf_seconds;
  logic [7:0]       qf_frames;
  logic [1:0]       qf_rate;
  logic [7:0]       qf_delta;
  logic [FPS_W-1:0] qf_fps;
  logic [7:0]       qf_jump;

  // free-wheel
  logic [FPS_W-1:0] cur_fps;
  logic [7:0]       cur_fps8;
  logic [4:0]       tk_hours;
  logic [7:0]       tk_minutes;
  logic [7:0]       tk_seconds;
  logic [7:0]       tk_frames;
  logic [4:0]       hr_inc;
  logic [7:0]       min_inc;
  logic [7:0]       sec_inc;
  logic [7:0]       frm_inc;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_command;
      s1_qf_r  <= in_qf_byte;
      s1_hb_r  <= in_ff_hour_byte;
      s1_min_r <= in_ff_minute;
      s1_sec_r <= in_ff_second;
      s1_frm_r <= in_ff_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r[0] <= FPS_RATE0_RST;
      fps_r[1] <= FPS_RATE1_RST;
      fps_r[2] <= FPS_RATE2_RST;
      fps_r[3] <= FPS_RATE3_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FPS_RATE0: fps_r[0] <= cfg_data;
        REG_FPS_RATE1: fps_r[1] <= cfg_data;
        REG_FPS_RATE2: fps_r[2] <= cfg_data;
        REG_FPS_RATE3: fps_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign piece = s1_qf_r[6:4];
  assign nib   = s1_qf_r[3:0];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slots_upd[i] = (piece == 3'(i)) ? nib : slots_r[i];
    end
  end

  // direction only follows pieces when neither this piece nor the previous one is the last one
  assign qf_forward  = (piece != LAST_PIECE && last_piece_r != LAST_PIECE) ?
                       (last_piece_r < piece) : forward_r;
  assign qf_complete = (qf_forward && piece == LAST_PIECE) ||
                       (!qf_forward && piece == FIRST_PIECE);

  assign qf_hours   = {slots_upd[7][0], slots_upd[6]};
  assign qf_minutes = {slots_upd[5], slots_upd[4]};
  assign qf_seconds = {slots_upd[3], slots_upd[2]};
  assign qf_frames  = {slots_upd[1], slots_upd[0]};
  assign qf_rate    = slots_upd[7][2:1];
  assign qf_delta   = (qf_frames < last_set_r) ? (last_set_r - qf_frames)
                                               : (qf_frames - last_set_r);
  assign qf_fps     = fps_r[qf_rate];
  // delta >= fps - 2 done as delta + 2 >= fps to stay unsigned
  assign qf_jump    = (({2'b00, qf_delta} + 10'd2) >= {5'b00000, qf_fps}) ?
                      JUMP_LIMIT : qf_delta;

  assign cur_fps  = fps_r[rate_r];
  assign cur_fps8 = {3'b000, cur_fps};
  assign frm_inc  = frames_r + 8'd1;
  assign sec_inc  = seconds_r + 8'd1;
  assign min_inc  = minutes_r + 8'd1;
  assign hr_inc   = hours_r + 5'd1;

  always_comb begin
    tk_hours   = hours_r;
    tk_minutes = minutes_r;
    tk_seconds = seconds_r;
    tk_frames  = frames_r;
    if (forward_r) begin
      tk_frames = frm_inc;
      if (frm_inc == cur_fps8) begin
        tk_frames  = 8'd0;
        tk_seconds = sec_inc;
        if (sec_inc == SEC_PER_MIN) begin
          tk_seconds = 8'd0;
          tk_minutes = min_inc;
          if (min_inc == MIN_PER_HR) begin
            tk_minutes = 8'd0;
            tk_hours   = (hr_inc == HR_PER_DAY) ? 5'd0 : hr_inc;
          end
        end
      end
    end else begin
      if (frames_r != 8'd0) begin
        tk_frames = frames_r - 8'd1;
      end else begin
        // borrow chain down through seconds, minutes and hours
        tk_frames = cur_fps8 - 8'd1;
        if (seconds_r != 8'd0) begin
          tk_seconds = seconds_r - 8'd1;
        end else begin
          tk_seconds = MAX_SEC;
          if (minutes_r != 8'd0) begin
            tk_minutes = minutes_r - 8'd1;
          end else begin
            tk_minutes = MAX_MIN;
            tk_hours   = (hours_r != 5'd0) ? (hours_r - 5'd1) : MAX_HR;
          end
        end
      end
    end
  end

  always_comb begin
    forward_nxt  = forward_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    frames_nxt   = frames_r;
    rate_nxt     = rate_r;
    last_set_nxt = last_set_r;
    jump_nxt     = jump_r;
    ticks_nxt    = ticks_r;
    pub_nxt      = 1'b0;
    restart_nxt  = 1'b0;
    unique case (s1_cmd_r)
      CMD_QUARTER_FRAME: begin
        forward_nxt = qf_forward;
        if (qf_complete) begin
          hours_nxt    = qf_hours;
          minutes_nxt  = qf_minutes;
          seconds_nxt  = qf_seconds;
          frames_nxt   = qf_frames;
          rate_nxt     = qf_rate;
          last_set_nxt = qf_frames;
          jump_nxt     = qf_jump;
          pub_nxt      = ticks_r < qf_jump;
          restart_nxt  = 1'b1;
          ticks_nxt    = 8'd0;
        end
      end
      CMD_FULL_FRAME: begin
        hours_nxt   = s1_hb_r[4:0];
        minutes_nxt = {1'b0, s1_min_r};
        seconds_nxt = {1'b0, s1_sec_r};
        frames_nxt  = {1'b0, s1_frm_r};
        rate_nxt    = s1_hb_r[6:5];
        pub_nxt     = 1'b1;
      end
      CMD_TIMER_TICK: begin
        ticks_nxt   = (ticks_r != TICKS_MAX) ? (ticks_r + 8'd1) : ticks_r;
        hours_nxt   = tk_hours;
        minutes_nxt = tk_minutes;
        seconds_nxt = tk_seconds;
        frames_nxt  = tk_frames;
        pub_nxt     = 1'b1;
        if (jump_r == JUMP_LIMIT) begin
          jump_nxt    = 8'd0;
          restart_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots_r[i] <= 4'd0;
      end
      last_piece_r <= 3'd0;
      forward_r    <= 1'b0;
      hours_r      <= 5'd0;
      minutes_r    <= 8'd0;
      seconds_r    <= 8'd0;
      frames_r     <= 8'd0;
      rate_r       <= 2'd0;
      last_set_r   <= 8'd0;
      jump_r       <= 8'd0;
      ticks_r      <= 8'd0;
    end else if (fire) begin
      if (s1_cmd_r == CMD_QUARTER_FRAME) begin
        slots_r[piece] <= nib;
        last_piece_r   <= piece;
      end
      forward_r  <= forward_nxt;
      hours_r    <= hours_nxt;
      minutes_r  <= minutes_nxt;
      seconds_r  <= seconds_nxt;
      frames_r   <= frames_nxt;
      rate_r     <= rate_nxt;
      last_set_r <= last_set_nxt;
      jump_r     <= jump_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pub_r       <= pub_nxt;
      restart_r   <= restart_nxt;
      hours_o_r   <= hours_nxt;
      minutes_o_r <= minutes_nxt;
      seconds_o_r <= seconds_nxt;
      frames_o_r  <= frames_nxt;
      rate_o_r    <= rate_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_publish       = pub_r;
  assign out_restart_timer = restart_r;
  assign out_hours         = hours_o_r;
  assign out_minutes       = minutes_o_r;
  assign out_seconds       = seconds_o_r;
  assign out_frames        = frames_o_r;
  assign out_rate_type     = rate_o_r;

endmodule

/* sv/mtcqfd_checker.sv */
module mtcqfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_publish,
  input logic       out_restart_timer,
  input logic [4:0] out_hours,
  input logic [7:0] out_minutes,
  input logic [7:0] out_seconds,
  input logic [7:0] out_frames,
  input logic [1:0] out_rate_type
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with no item taken last cycle and nothing held at the output, the input
  // stage has drained and must be open
  a_drained_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid && in_ready) && !out_valid |-> in_ready)
    else $error("input stalled while pipeline is empty");

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_publish) &&
    $stable(out_restart_timer) && $stable(out_hours) && $stable(out_minutes) &&
    $stable(out_seconds) && $stable(out_frames) && $stable(out_rate_type))
    else $error("stalled result changed");

  // the output stage frees a slot whenever its item is taken
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input blocked while result is being taken");

endmodule

bind mtc_quarter_frame_decoder_top mtcqfd_checker u_mtcqfd_checker (.*);

/* tb/sv/mtc_timecode_checker.sv */
`timescale 1ns / 100ps

module mtc_timecode_checker
  import mtcqfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_qf_byte,
  input  logic [6:0] in_ff_hour_byte,
  input  logic [6:0] in_ff_minute,
  input  logic [6:0] in_ff_second,
  input  logic [6:0] in_ff_frame,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_publish,
  input  logic       out_restart_timer,
  input  logic [4:0] out_hours,
  input  logic [7:0] out_minutes,
  input  logic [7:0] out_seconds,
  input  logic [7:0] out_frames,
  input  logic [1:0] out_rate_type,
  output int         pending_results,
  output int         mismatch_count
);

  typedef struct packed {
    logic       publish;
    logic       restart;
    logic [4:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] frames;
    logic [1:0] rate;
  } tc_result_t;

  // decoder state as the block should hold it
  logic [3:0] qf_slots [NUM_SLOTS];
  logic [2:0] prev_piece;
  logic       play_fwd;
  logic [4:0] cur_hh;
  logic [7:0] cur_mm;
  logic [7:0] cur_ss;
  logic [7:0] cur_ff;
  logic [1:0] cur_rate;
  logic [7:0] set_frame;
  logic [7:0] jump_frames;
  logic [7:0] ticks_seen;
  logic [FPS_W-1:0] fps_regs [4];

  tc_result_t expected_times [$];
  tc_result_t got;
  tc_result_t want;
  int         bad = 0;

  function automatic string fmt_time(tc_result_t r);
    return $sformatf("pub %0b restart %0b %0d:%0d:%0d:%0d rate %0d",
                     r.publish, r.restart, r.hours, r.minutes, r.seconds, r.frames, r.rate);
  endfunction

  function automatic tc_result_t decode_item(logic [1:0] cmd, logic [6:0] qf, logic [6:0] hb,
                                             logic [6:0] mn, logic [6:0] sc, logic [6:0] fr);
    tc_result_t       r;
    logic [2:0]       piece;
    logic [7:0]       delta;
    logic [FPS_W-1:0] fps;
    r.publish = 1'b0;
    r.restart = 1'b0;
    case (cmd)
      CMD_QUARTER_FRAME: begin
        piece = qf[6:4];
        qf_slots[piece] = qf[3:0];
        // direction only follows pieces when neither this piece nor the previous one is the top slot
        if (piece != LAST_PIECE && prev_piece != LAST_PIECE)
          play_fwd = (prev_piece < piece);
        if ((play_fwd && piece == LAST_PIECE) || (!play_fwd && piece == FIRST_PIECE)) begin
          cur_hh   = {qf_slots[7][0], qf_slots[6]};
          cur_mm   = {qf_slots[5], qf_slots[4]};
          cur_ss   = {qf_slots[3], qf_slots[2]};
          cur_ff   = {qf_slots[1], qf_slots[0]};
          cur_rate = qf_slots[7][2:1];
          delta = (cur_ff < set_frame) ? set_frame - cur_ff : cur_ff - set_frame;
          set_frame = cur_ff;
          if (int'(delta) >= int'(fps_regs[cur_rate]) - 2)
            delta = JUMP_LIMIT;
          jump_frames = delta;
          r.publish = (ticks_seen < jump_frames);
          r.restart = 1'b1;
          ticks_seen = '0;
        end
        prev_piece = piece;
      end
      CMD_FULL_FRAME: begin
        cur_hh   = hb[4:0];
        cur_mm   = {1'b0, mn};
        cur_ss   = {1'b0, sc};
        cur_ff   = {1'b0, fr};
        cur_rate = hb[6:5];
        r.publish = 1'b1;
      end
      CMD_TIMER_TICK: begin
        if (ticks_seen != TICKS_MAX)
          ticks_seen = ticks_seen + 8'd1;
        fps = fps_regs[cur_rate];
        if (play_fwd) begin
          cur_ff = cur_ff + 8'd1;
          if (cur_ff == {3'b000, fps}) begin
            cur_ff = '0;
            cur_ss = cur_ss + 8'd1;
            if (cur_ss == SEC_PER_MIN) begin
              cur_ss = '0;
              cur_mm = cur_mm + 8'd1;
              if (cur_mm == MIN_PER_HR) begin
                cur_mm = '0;
                cur_hh = cur_hh + 5'd1;
                if (cur_hh == HR_PER_DAY)
                  cur_hh = '0;
              end
            end
          end
        end else if (cur_ff != 8'd0) begin
          cur_ff = cur_ff - 8'd1;
        end else begin
          // borrow chain down through seconds, minutes and hours
          cur_ff = {3'b000, fps} - 8'd1;
          if (cur_ss != 8'd0) begin
            cur_ss = cur_ss - 8'd1;
          end else begin
            cur_ss = MAX_SEC;
            if (cur_mm != 8'd0) begin
              cur_mm = cur_mm - 8'd1;
            end else begin
              cur_mm = MAX_MIN;
              cur_hh = (cur_hh != 5'd0) ? cur_hh - 5'd1 : MAX_HR;
            end
          end
        end
        r.publish = 1'b1;
        if (jump_frames == JUMP_LIMIT) begin
          jump_frames = '0;
          r.restart = 1'b1;
        end
      end
      default: ;
    endcase
    r.hours   = cur_hh;
    r.minutes = cur_mm;
    r.seconds = cur_ss;
    r.frames  = cur_ff;
    r.rate    = cur_rate;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (qf_slots[i]) qf_slots[i] = '0;
      prev_piece  = '0;
      play_fwd    = 1'b0;
      cur_hh      = '0;
      cur_mm      = '0;
      cur_ss      = '0;
      cur_ff      = '0;
      cur_rate    = '0;
      set_frame   = '0;
      jump_frames = '0;
      ticks_seen  = '0;
      fps_regs[0] = FPS_RATE0_RST;
      fps_regs[1] = FPS_RATE1_RST;
      fps_regs[2] = FPS_RATE2_RST;
      fps_regs[3] = FPS_RATE3_RST;
      expected_times.delete();
    end else begin
      if (cfg_wr_en)
        fps_regs[cfg_index] = cfg_data;
      // retire before predicting: a result never leaves in the cycle its item enters
      if (out_valid && out_ready) begin
        got = '{publish: out_publish, restart: out_restart_timer, hours: out_hours,
                minutes: out_minutes, seconds: out_seconds, frames: out_frames,
                rate: out_rate_type};
        if (expected_times.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t: unexpected result item %s", $realtime, fmt_time(got));
        end else begin
          want = expected_times.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= 10)
              $display("%0t: result mismatch, expected %s, got %s", $realtime,
                       fmt_time(want), fmt_time(got));
          end
        end
      end
      if (in_valid && in_ready)
        expected_times.push_back(decode_item(in_command, in_qf_byte, in_ff_hour_byte,
                                             in_ff_minute, in_ff_second, in_ff_frame));
    end
    pending_results <= expected_times.size();
    mismatch_count  <= bad;
  end

endmodule

/* tb/sv/tb_mtc_quarter_frame_decoder_top.sv */
`timescale 1ns / 100ps

module tb_mtc_quarter_frame_decoder_top;
  import mtcqfd_pkg::*;

  // command code the block has no meaning for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  reg_idx_t   cfg_index = REG_FPS_RATE0;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = CMD_QUARTER_FRAME;
  logic [6:0] in_qf_byte = '0;
  logic [6:0] in_ff_hour_byte = '0;
  logic [6:0] in_ff_minute = '0;
  logic [6:0] in_ff_second = '0;
  logic [6:0] in_ff_frame = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_publish;
  logic       out_restart_timer;
  logic [4:0] out_hours;
  logic [7:0] out_minutes;
  logic [7:0] out_seconds;
  logic [7:0] out_frames;
  logic [1:0] out_rate_type;

  int pending_results;
  int mismatch_count;

  logic [4:0] fps_now [4] = '{FPS_RATE0_RST, FPS_RATE1_RST, FPS_RATE2_RST, FPS_RATE3_RST};
  int         items_sent = 0;
  int         burst_left = 0;
  int         last_set_ff = 0;
  logic [9:0] ready_phase = '0;

  always #6 clk = ~clk;

  mtc_quarter_frame_decoder_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_qf_byte        (in_qf_byte),
    .in_ff_hour_byte   (in_ff_hour_byte),
    .in_ff_minute      (in_ff_minute),
    .in_ff_second      (in_ff_second),
    .in_ff_frame       (in_ff_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_publish       (out_publish),
    .out_restart_timer (out_restart_timer),
    .out_hours         (out_hours),
    .out_minutes       (out_minutes),
    .out_seconds       (out_seconds),
    .out_frames        (out_frames),
    .out_rate_type     (out_rate_type)
  );

  mtc_timecode_checker u_timecode_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_qf_byte        (in_qf_byte),
    .in_ff_hour_byte   (in_ff_hour_byte),
    .in_ff_minute      (in_ff_minute),
    .in_ff_second      (in_ff_second),
    .in_ff_frame       (in_ff_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_publish       (out_publish),
    .out_restart_timer (out_restart_timer),
    .out_hours         (out_hours),
    .out_minutes       (out_minutes),
    .out_seconds       (out_seconds),
    .out_frames        (out_frames),
    .out_rate_type     (out_rate_type),
    .pending_results   (pending_results),
    .mismatch_count    (mismatch_count)
  );

  // receiver: always ready, random, sparse and mostly ready stretches in turn
  always @(posedge clk) begin
    ready_phase <= ready_phase + 10'd1;
    case (ready_phase[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (ready_phase[1:0] == 2'd3);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_item(logic [1:0] cmd, logic [6:0] qf, logic [6:0] hb,
                           logic [6:0] mn, logic [6:0] sc, logic [6:0] fr);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_qf_byte      <= qf;
    in_ff_hour_byte <= hb;
    in_ff_minute    <= mn;
    in_ff_second    <= sc;
    in_ff_frame     <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(CMD_TIMER_TICK, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
              7'($urandom));
  endtask

  // quarter-frame pieces of one time, in play order or reversed, possibly cut short
  task automatic send_set(bit fwd_dir, logic [4:0] hh, logic [7:0] mm, logic [7:0] ss,
                          logic [7:0] ff, logic [1:0] rt, int n_pieces);
    logic [3:0] nib [8];
    logic [2:0] p;
    nib[0] = ff[3:0];
    nib[1] = ff[7:4];
    nib[2] = ss[3:0];
    nib[3] = ss[7:4];
    nib[4] = mm[3:0];
    nib[5] = mm[7:4];
    nib[6] = hh[3:0];
    nib[7] = {1'($urandom), rt, hh[4]};
    for (int k = 0; k < n_pieces; k++) begin
      p = fwd_dir ? 3'(k) : 3'(7 - k);
      send_item(CMD_QUARTER_FRAME, {p, nib[p]}, 7'($urandom), 7'($urandom), 7'($urandom),
                7'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rates(logic [4:0] r0, logic [4:0] r1, logic [4:0] r2, logic [4:0] r3);
    logic [4:0] rates [4];
    rates = '{r0, r1, r2, r3};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= rates[i];
      fps_now[i] = rates[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_traffic(int n_items, bit tick_run);
    int         start;
    int         kind;
    logic [1:0] rt;
    logic [4:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    logic [7:0] ff;
    start = items_sent;
    // long tick run drives the tick counter into saturation
    if (tick_run)
      repeat (270) send_tick();
    while (items_sent - start < n_items) begin
      kind = $urandom_range(0, 99);
      rt = 2'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        hh = 5'($urandom);
        mm = 8'($urandom);
        ss = 8'($urandom);
        ff = 8'($urandom);
      end else begin
        hh = 5'($urandom_range(0, 23));
        mm = 8'($urandom_range(0, 59));
        ss = 8'($urandom_range(0, 59));
        // small frame steps between sets usually keep the jump below the limit when the rate is large enough
        if ($urandom_range(0, 3) == 0)
          ff = 8'($urandom_range(0, fps_now[rt] - 1));
        else
          ff = 8'((last_set_ff + $urandom_range(0, 5)) % fps_now[rt]);
      end
      if (kind < 55) begin
        send_set($urandom_range(0, 3) != 0, hh, mm, ss, ff, rt, 8);
        last_set_ff = ff;
        repeat ($urandom_range(0, 3)) send_tick();
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (kind < 82) begin
        if ($urandom_range(0, 1) == 0)
          send_item(CMD_FULL_FRAME, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                    7'($urandom));
        else
          send_item(CMD_FULL_FRAME, 7'($urandom), {rt, hh}, mm[6:0], ss[6:0], ff[6:0]);
      end else if (kind < 88) begin
        send_set(1'($urandom_range(0, 1)), hh, mm, ss, ff, rt, $urandom_range(1, 7));
      end else if (kind < 94) begin
        send_item(CMD_QUARTER_FRAME, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                  7'($urandom));
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? CMD_UNUSED : 2'($urandom), 7'($urandom),
                  7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, carry and borrow chains, unused command, both set orders
    send_item(CMD_FULL_FRAME, 7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
    send_item(CMD_TIMER_TICK, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00);
    send_item(CMD_UNUSED, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
    send_item(CMD_FULL_FRAME, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
    send_item(CMD_TIMER_TICK, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
    send_set(1'b1, 5'd23, 8'd59, 8'd59, 8'd23, 2'd0, 8);
    send_tick();
    send_set(1'b0, 5'd0, 8'd0, 8'd0, 8'd0, 2'd3, 8);
    send_tick();
    send_item(CMD_QUARTER_FRAME, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00);
    send_item(CMD_QUARTER_FRAME, 7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h7F);

    drain();
    write_rates(5'd1, 5'd1, 5'd1, 5'd1);
    run_traffic(200, 1'b0);
    drain();
    write_rates(5'd31, 5'd31, 5'd31, 5'd31);
    run_traffic(200, 1'b1);
    drain();
    write_rates(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)),
                5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
    run_traffic(220, 1'b0);
    drain();
    write_rates(5'd24, 5'd25, 5'd30, 5'd30);
    run_traffic(240, 1'b0);
    drain();
    write_rates(5'd2, 5'd3, 5'd4, 5'd5);
    run_traffic(200, 1'b0);
    drain();
    write_rates(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)),
                5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
    run_traffic(240, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
